// ===== design/ses_pkg.sv =====
// Shared types and constants of the sparse extent scanner.
package ses_pkg;

  localparam int BLOCK_BYTES_DEF = 512;
  localparam int LANE_BYTES_DEF  = 8;
  localparam int OFFSET_BITS_DEF = 48;

  localparam int DATA_W    = 64;
  localparam int NB_W      = 4;
  localparam int LANES     = DATA_W / 8;
  // Holds any block byte count up to the largest allowed block plus one word.
  localparam int CNT_W     = 13;
  localparam int OUT_W     = 48;
  localparam int EVQ_DEPTH = 4;
  localparam int EVQ_PTR_W = 2;

  // One finished block, as handed from the front to the back.
  typedef struct packed {
    logic [CNT_W-1:0] cnt;
    logic             has_data;
    logic             file_end;
    logic             sat;
  } event_t;

  // One extent as delivered on the output stream.
  typedef struct packed {
    logic [OUT_W-1:0] eff_size;
    logic [OUT_W-1:0] file_size;
    logic [OUT_W-1:0] nbytes;
    logic [OUT_W-1:0] offset;
    logic             last;
    logic             ovf;
  } result_t;

endpackage

// ===== design/ses_front.sv =====
// Front end: gathers words into blocks, zero-tests them and posts block events.
module ses_front #(
  parameter int BLOCK_BYTES = ses_pkg::BLOCK_BYTES_DEF,
  parameter int LANE_BYTES  = ses_pkg::LANE_BYTES_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [ses_pkg::DATA_W-1:0] data_word,
  input  logic [ses_pkg::NB_W-1:0]   valid_bytes,
  input  logic                      block_end,
  input  logic                      file_end,
  output logic                      ev_valid,
  input  logic                      ev_ready,
  output ses_pkg::event_t           ev
);

  logic [ses_pkg::CNT_W-1:0] block_count;
  logic                      block_has_data;
  logic                      sat_sticky;

  logic [ses_pkg::NB_W-1:0]  nb;
  logic [ses_pkg::LANES-1:0] byte_nz;
  logic                      word_nz;
  logic [ses_pkg::CNT_W-1:0] sum;
  logic [ses_pkg::CNT_W-1:0] cnt_next;
  logic                      sat_now;
  logic                      ends_block;
  logic                      accept;

  always_comb begin
    nb = (valid_bytes > ses_pkg::NB_W'(LANE_BYTES)) ? ses_pkg::NB_W'(LANE_BYTES) : valid_bytes;
    for (int i = 0; i < ses_pkg::LANES; i++) begin
      byte_nz[i] = (ses_pkg::NB_W'(i) < nb) && (|data_word[8*i +: 8]);
    end
    word_nz = |byte_nz;
    sum = block_count + ses_pkg::CNT_W'(nb);
    sat_now = sum > ses_pkg::CNT_W'(BLOCK_BYTES);
    cnt_next = sat_now ? ses_pkg::CNT_W'(BLOCK_BYTES) : sum;
  end

  assign ends_block = block_end || file_end;
  assign in_ready   = ev_ready;
  assign accept     = in_valid && in_ready;

  assign ev_valid    = accept && ends_block;
  assign ev.cnt      = cnt_next;
  assign ev.has_data = block_has_data || word_nz;
  assign ev.file_end = file_end;
  assign ev.sat      = sat_sticky || sat_now;

  always_ff @(posedge clk) begin
    if (rst) begin
      block_count    <= '0;
      block_has_data <= 1'b0;
      sat_sticky     <= 1'b0;
    end else if (accept) begin
      if (ends_block) begin
        block_count    <= '0;
        block_has_data <= 1'b0;
        // The overflow flag lives until the file's last extent has been posted.
        sat_sticky     <= file_end ? 1'b0 : (sat_sticky || sat_now);
      end else begin
        block_count    <= cnt_next;
        block_has_data <= block_has_data || word_nz;
        sat_sticky     <= sat_sticky || sat_now;
      end
    end
  end

endmodule

// ===== design/ses_queue.sv =====
// Short queue of block events between the front and the back.
module ses_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            wr_valid,
  output logic            wr_ready,
  input  ses_pkg::event_t wr_data,
  output logic            rd_valid,
  input  logic            rd_ready,
  output ses_pkg::event_t rd_data
);

  ses_pkg::event_t              mem [ses_pkg::EVQ_DEPTH];
  logic [ses_pkg::EVQ_PTR_W-1:0] wr_ptr;
  logic [ses_pkg::EVQ_PTR_W-1:0] rd_ptr;
  logic [ses_pkg::EVQ_PTR_W:0]   count;
  logic                          push;
  logic                          pop;

  assign wr_ready = count != (ses_pkg::EVQ_PTR_W + 1)'(ses_pkg::EVQ_DEPTH);
  assign rd_valid = count != '0;
  assign rd_data  = mem[rd_ptr];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== design/ses_back.sv =====
// Back end: keeps the run and size counters and emits extents.
module ses_back #(
  parameter int OFFSET_BITS = ses_pkg::OFFSET_BITS_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            ev_valid,
  output logic            ev_ready,
  input  ses_pkg::event_t ev,
  output logic            out_valid,
  input  logic            out_ready,
  output ses_pkg::result_t out_data
);

  localparam int OB = OFFSET_BITS;

  logic [OB-1:0] file_offset;
  logic [OB-1:0] data_total;
  logic [OB-1:0] run_start;
  logic [OB-1:0] run_length;
  logic          saturated;

  ses_pkg::result_t pend_data;
  logic             pend_valid;

  logic [OB-1:0] cnt_ext;
  logic [OB:0]   fo_add;
  logic [OB:0]   dt_add;
  logic [OB:0]   rl_add;
  logic [OB-1:0] fo_next;
  logic [OB-1:0] dt_next;
  logic [OB-1:0] rs_next;
  logic [OB-1:0] rl_next;
  logic [OB-1:0] rs_final;
  logic          sat_in;
  logic          sat_next;
  logic          nonempty;
  logic          emit_a;
  logic          emit_b;
  logic          pop;
  ses_pkg::result_t res_a;
  ses_pkg::result_t res_b;

  // Saturating add; the top bit of the result flags saturation.
  function automatic logic [OB:0] sat_add(input logic [OB-1:0] a, input logic [OB-1:0] b);
    logic [OB:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s[OB]) begin
      s = {1'b1, {OB{1'b1}}};
    end
    return s;
  endfunction

  always_comb begin
    cnt_ext  = OB'(ev.cnt);
    nonempty = ev.cnt != '0;
    sat_in   = saturated || ev.sat;
    fo_add   = sat_add(file_offset, cnt_ext);
    dt_add   = sat_add(data_total, cnt_ext);
    rl_add   = sat_add(run_length, cnt_ext);

    fo_next  = file_offset;
    dt_next  = data_total;
    rs_next  = run_start;
    rl_next  = run_length;
    sat_next = sat_in;
    emit_a   = 1'b0;

    if (nonempty) begin
      fo_next  = fo_add[OB-1:0];
      sat_next = sat_in || fo_add[OB];
      if (!ev.has_data) begin
        // A zero block closes the open run.
        if (run_length != '0) begin
          emit_a = 1'b1;
        end
        rl_next = '0;
      end else begin
        dt_next  = dt_add[OB-1:0];
        rs_next  = (run_length == '0) ? file_offset : run_start;
        rl_next  = rl_add[OB-1:0];
        sat_next = sat_in || fo_add[OB] || dt_add[OB] || rl_add[OB];
      end
    end

    emit_b   = ev.file_end;
    rs_final = (rl_next == '0) ? fo_next : rs_next;

    res_a.offset    = ses_pkg::OUT_W'(run_start);
    res_a.nbytes    = ses_pkg::OUT_W'(run_length);
    res_a.file_size = '0;
    res_a.eff_size  = '0;
    res_a.last      = 1'b0;
    res_a.ovf       = sat_in;

    res_b.offset    = ses_pkg::OUT_W'(rs_final);
    res_b.nbytes    = ses_pkg::OUT_W'(rl_next);
    res_b.file_size = ses_pkg::OUT_W'(fo_next);
    res_b.eff_size  = ses_pkg::OUT_W'(dt_next);
    res_b.last      = 1'b1;
    res_b.ovf       = sat_next;
  end

  assign ev_ready = (!out_valid || out_ready) && !pend_valid;
  assign pop      = ev_valid && ev_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      file_offset <= '0;
      data_total  <= '0;
      run_start   <= '0;
      run_length  <= '0;
      saturated   <= 1'b0;
    end else if (pop) begin
      if (ev.file_end) begin
        file_offset <= '0;
        data_total  <= '0;
        run_start   <= '0;
        run_length  <= '0;
        saturated   <= 1'b0;
      end else begin
        file_offset <= fo_next;
        data_total  <= dt_next;
        run_start   <= rs_next;
        run_length  <= rl_next;
        saturated   <= sat_next;
      end
    end
  end

  // Output register plus one holding slot for the second extent of a block.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      pend_valid <= 1'b0;
    end else if (pop) begin
      if (emit_a && emit_b) begin
        out_data   <= res_a;
        out_valid  <= 1'b1;
        pend_data  <= res_b;
        pend_valid <= 1'b1;
      end else if (emit_a) begin
        out_data  <= res_a;
        out_valid <= 1'b1;
      end else if (emit_b) begin
        out_data  <= res_b;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end else if (pend_valid && (out_ready || !out_valid)) begin
      out_data   <= pend_data;
      out_valid  <= 1'b1;
      pend_valid <= 1'b0;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

// ===== design/sparse_extent_scanner.sv =====
// Top level of the sparse extent scanner.
//
// The scanner takes one input word per clock cycle while its output keeps up.
// The front gathers words into blocks and zero-tests each one in the cycle it
// arrives; every block end posts an event into a four-entry queue. The back
// handles one block event per cycle while the output is not held off and no
// second extent waits, and writes its extent into an output register, so an
// extent passes through the queue and then the output register after the
// transfer of the word that ends its block. A zero block that closes a run at
// end of file gives two extents, which leave the output one after the other
// while the back waits. The queue absorbs an occasional such file; the input
// stalls on a full queue: the output is held off or such files follow closely.
module sparse_extent_scanner #(
  parameter int BLOCK_BYTES = ses_pkg::BLOCK_BYTES_DEF,
  parameter int LANE_BYTES  = ses_pkg::LANE_BYTES_DEF,
  parameter int OFFSET_BITS = ses_pkg::OFFSET_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // data_word [63:0], valid_bytes [67:64], zero [71:68]
  input  logic [71:0]  s_tdata,
  // block_end [0]
  input  logic         s_tuser,
  input  logic         s_tlast,
  output logic         m_tvalid,
  input  logic         m_tready,
  // extent_offset [47:0], extent_bytes [95:48], file_size [143:96],
  // data_size [191:144]
  output logic [191:0] m_tdata,
  // overflow [0]
  output logic         m_tuser,
  output logic         m_tlast
);

  logic             fq_valid;
  logic             fq_ready;
  ses_pkg::event_t  fq_data;
  logic             qb_valid;
  logic             qb_ready;
  ses_pkg::event_t  qb_data;
  ses_pkg::result_t result;

  ses_front #(
    .BLOCK_BYTES (BLOCK_BYTES),
    .LANE_BYTES  (LANE_BYTES)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_tvalid),
    .in_ready    (s_tready),
    .data_word   (s_tdata[63:0]),
    .valid_bytes (s_tdata[67:64]),
    .block_end   (s_tuser),
    .file_end    (s_tlast),
    .ev_valid    (fq_valid),
    .ev_ready    (fq_ready),
    .ev          (fq_data)
  );

  ses_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (fq_valid),
    .wr_ready (fq_ready),
    .wr_data  (fq_data),
    .rd_valid (qb_valid),
    .rd_ready (qb_ready),
    .rd_data  (qb_data)
  );

  ses_back #(
    .OFFSET_BITS (OFFSET_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .ev_valid  (qb_valid),
    .ev_ready  (qb_ready),
    .ev        (qb_data),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (result)
  );

  assign m_tdata = {result.eff_size, result.file_size, result.nbytes, result.offset};
  assign m_tuser = result.ovf;
  assign m_tlast = result.last;

endmodule
